[src/ucv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucv_pkg
// Shared types and constants of the URI component validator: grammar
// codes, the item and result records and default sizes.
// ----------------------------------------------------------------------------
package ucv_pkg;

  typedef enum logic [3:0] {
    KIND_SCHEME         = 4'd0,
    KIND_SEGMENT        = 4'd1,
    KIND_SEGMENT_NZ     = 4'd2,
    KIND_SEGMENT_NZ_NC  = 4'd3,
    KIND_PATH_ABEMPTY   = 4'd4,
    KIND_PATH_ABSOLUTE  = 4'd5,
    KIND_PATH_NOSCHEME  = 4'd6,
    KIND_PATH_ROOTLESS  = 4'd7,
    KIND_REG_NAME       = 4'd8,
    KIND_USERINFO       = 4'd9,
    KIND_QUERY          = 4'd10,
    KIND_FRAGMENT       = 4'd11,
    KIND_PORT           = 4'd12,
    KIND_H16            = 4'd13,
    KIND_IPV4           = 4'd14,
    KIND_DEC_OCTET      = 4'd15
  } ucv_kind_e;

  localparam ucv_kind_e KindReset = KIND_SEGMENT;

  localparam int unsigned CountBitsDefault = 16;
  localparam int unsigned CharCountW       = 16;

  typedef struct packed {
    logic       action;
    logic [7:0] char_byte;
  } ucv_item_t;

  typedef struct packed {
    logic                  accepted;
    logic [CharCountW-1:0] char_count;
  } ucv_result_t;

endpackage

[src/ucv_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucv_step
// Per-string scan state and the one-character update: character classes,
// percent triplets, path position, segment length, octet digits and dots.
// ----------------------------------------------------------------------------
module ucv_step #(
  parameter int unsigned COUNT_BITS = ucv_pkg::CountBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ucv_pkg::ucv_kind_e  kind_i,
  input  logic                fire_i,
  input  ucv_pkg::ucv_item_t  item_i,
  output ucv_pkg::ucv_result_t result_o
);

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChAt      = 8'h40;
  localparam logic [7:0] ChQuest   = 8'h3F;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChTilde   = 8'h7E;
  localparam logic [7:0] ChUnder   = 8'h5F;

  localparam logic [1:0] PctNone = 2'd0;
  localparam logic [1:0] PctOpen = 2'd1;
  localparam logic [1:0] PctHex1 = 2'd2;

  localparam logic [1:0] PhaseStart = 2'd0;
  localparam logic [1:0] PhaseFirst = 2'd1;
  localparam logic [1:0] PhaseRest  = 2'd2;

  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [COUNT_BITS-1:0] H16Max   = COUNT_BITS'(4);
  localparam logic [11:0]           OctetMax = 12'd255;
  localparam logic [1:0]            DotsMax  = 2'd3;
  localparam logic [1:0]            DigsMax  = 2'd3;

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = is_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic is_unres(input logic [7:0] c);
    is_unres = is_alpha(c) || is_digit(c) || c == ChMinus || c == ChDot ||
               c == ChUnder || c == ChTilde;
  endfunction

  function automatic logic is_subdelim(input logic [7:0] c);
    is_subdelim = c == 8'h21 || c == 8'h24 || c == 8'h26 || c == 8'h27 || c == 8'h28 ||
                  c == 8'h29 || c == 8'h2A || c == 8'h2B || c == 8'h2C || c == 8'h3B ||
                  c == 8'h3D;
  endfunction

  logic                  fail_q, fail_d;
  logic [1:0]            pct_q, pct_d;
  logic [COUNT_BITS-1:0] seg_q, seg_d;
  logic [1:0]            phase_q, phase_d;
  logic [1:0]            dots_q, dots_d;
  logic [1:0]            digs_q, digs_d;
  logic [8:0]            oval_q, oval_d;
  logic [COUNT_BITS-1:0] total_q, total_d;

  logic [7:0]  c;
  logic        c_pct, c_slash, c_digit, c_hex;
  logic        cls_unres_sub, cls_nc, cls_pchar, cls_query, cls_user;
  logic        first;
  logic [11:0] oct_next;
  logic        oct_ok;
  logic        ok;
  logic        end_ok;
  logic        nonempty;

  assign c             = item_i.char_byte;
  assign c_pct         = c == ChPercent;
  assign c_slash       = c == ChSlash;
  assign c_digit       = is_digit(c);
  assign c_hex         = is_hex(c);
  assign cls_unres_sub = is_unres(c) || is_subdelim(c);
  assign cls_nc        = cls_unres_sub || c == ChAt;
  assign cls_pchar     = cls_nc || c == ChColon;
  assign cls_query     = cls_pchar || c_slash || c == ChQuest;
  assign cls_user      = cls_unres_sub || c == ChColon;
  assign first         = total_q == '0;
  assign nonempty      = !first;

  // decimal octet digit: value * 10 + digit
  assign oct_next = {oval_q, 3'b000} + {2'b00, oval_q, 1'b0} + {4'd0, c - ChZero};
  assign oct_ok   = c_digit && (digs_q < DigsMax) && !((digs_q != 2'd0) && (oval_q == 9'd0)) &&
                    (oct_next <= OctetMax);

  always_comb begin
    fail_d  = fail_q;
    pct_d   = pct_q;
    seg_d   = seg_q;
    phase_d = phase_q;
    dots_d  = dots_q;
    digs_d  = digs_q;
    oval_d  = oval_q;
    total_d = total_q;
    ok      = 1'b1;
    if (fire_i) begin
      if (item_i.action) begin
        fail_d  = 1'b0;
        pct_d   = PctNone;
        seg_d   = '0;
        phase_d = PhaseStart;
        dots_d  = 2'd0;
        digs_d  = 2'd0;
        oval_d  = 9'd0;
        total_d = '0;
      end else begin
        if (!fail_q) begin
          if (pct_q != PctNone) begin
            if (c_hex) begin
              pct_d = (pct_q == PctOpen) ? PctHex1 : PctNone;
            end else begin
              fail_d = 1'b1;
            end
          end else begin
            case (kind_i)
              ucv_pkg::KIND_SCHEME: begin
                ok = first ? is_alpha(c)
                           : (is_alpha(c) || c_digit || c == ChPlus || c == ChMinus ||
                              c == ChDot);
              end
              ucv_pkg::KIND_SEGMENT, ucv_pkg::KIND_SEGMENT_NZ: begin
                ok = cls_pchar || c_pct;
                if (c_pct) pct_d = PctOpen;
              end
              ucv_pkg::KIND_SEGMENT_NZ_NC: begin
                ok = cls_nc || c_pct;
                if (c_pct) pct_d = PctOpen;
              end
              ucv_pkg::KIND_PATH_ABEMPTY: begin
                if (phase_q == PhaseStart) begin
                  phase_d = PhaseRest;
                  ok      = c_slash;
                end else begin
                  ok = c_slash || cls_pchar || c_pct;
                  if (c_pct) pct_d = PctOpen;
                end
              end
              ucv_pkg::KIND_PATH_ABSOLUTE: begin
                if (phase_q == PhaseStart) begin
                  phase_d = PhaseFirst;
                  seg_d   = '0;
                  ok      = c_slash;
                end else if (phase_q == PhaseFirst) begin
                  if (c_slash) begin
                    phase_d = PhaseRest;
                    ok      = seg_q != '0;
                  end else begin
                    if (seg_q != CountMax) seg_d = seg_q + 1'b1;
                    ok = cls_pchar || c_pct;
                    if (c_pct) pct_d = PctOpen;
                  end
                end else begin
                  ok = c_slash || cls_pchar || c_pct;
                  if (c_pct) pct_d = PctOpen;
                end
              end
              ucv_pkg::KIND_PATH_NOSCHEME, ucv_pkg::KIND_PATH_ROOTLESS: begin
                if (phase_q == PhaseStart || phase_q == PhaseFirst) begin
                  if (c_slash) begin
                    phase_d = (phase_q == PhaseStart) ? PhaseFirst : PhaseRest;
                    ok      = phase_q != PhaseStart;
                  end else begin
                    phase_d = PhaseFirst;
                    ok = ((kind_i == ucv_pkg::KIND_PATH_NOSCHEME) ? cls_nc : cls_pchar) ||
                         c_pct;
                    if (c_pct) pct_d = PctOpen;
                  end
                end else begin
                  ok = c_slash || cls_pchar || c_pct;
                  if (c_pct) pct_d = PctOpen;
                end
              end
              ucv_pkg::KIND_REG_NAME: begin
                ok = cls_unres_sub || c_pct;
                if (c_pct) pct_d = PctOpen;
              end
              ucv_pkg::KIND_USERINFO: begin
                ok = cls_user || c_pct;
                if (c_pct) pct_d = PctOpen;
              end
              ucv_pkg::KIND_QUERY, ucv_pkg::KIND_FRAGMENT: begin
                ok = cls_query || c_pct;
                if (c_pct) pct_d = PctOpen;
              end
              ucv_pkg::KIND_PORT: begin
                ok = c_digit;
              end
              ucv_pkg::KIND_H16: begin
                ok = c_hex && (seg_q < H16Max);
                if (ok) seg_d = seg_q + 1'b1;
              end
              ucv_pkg::KIND_IPV4: begin
                if (c == ChDot) begin
                  ok = (digs_q != 2'd0) && (dots_q < DotsMax);
                  if (ok) begin
                    dots_d = dots_q + 1'b1;
                    digs_d = 2'd0;
                    oval_d = 9'd0;
                  end
                end else begin
                  ok = oct_ok;
                  if (oct_ok) begin
                    oval_d = oct_next[8:0];
                    digs_d = digs_q + 1'b1;
                  end
                end
              end
              default: begin
                ok = oct_ok;
                if (oct_ok) begin
                  oval_d = oct_next[8:0];
                  digs_d = digs_q + 1'b1;
                end
              end
            endcase
            if (!ok) fail_d = 1'b1;
          end
        end
        if (total_q != CountMax) total_d = total_q + 1'b1;
      end
    end
  end

  always_comb begin
    end_ok = 1'b1;
    case (kind_i)
      ucv_pkg::KIND_SCHEME, ucv_pkg::KIND_SEGMENT_NZ, ucv_pkg::KIND_SEGMENT_NZ_NC,
      ucv_pkg::KIND_PATH_ABSOLUTE, ucv_pkg::KIND_PATH_NOSCHEME,
      ucv_pkg::KIND_PATH_ROOTLESS, ucv_pkg::KIND_H16: begin
        end_ok = nonempty;
      end
      ucv_pkg::KIND_IPV4: begin
        end_ok = (dots_q == DotsMax) && (digs_q != 2'd0);
      end
      ucv_pkg::KIND_DEC_OCTET: begin
        end_ok = digs_q != 2'd0;
      end
      default: begin
        end_ok = 1'b1;
      end
    endcase
  end

  assign result_o.accepted = end_ok && !fail_q && (pct_q == PctNone);

  if (COUNT_BITS > ucv_pkg::CharCountW) begin : g_count_sat
    assign result_o.char_count = (|total_q[COUNT_BITS-1:ucv_pkg::CharCountW]) ? '1
                               : total_q[ucv_pkg::CharCountW-1:0];
  end else begin : g_count_ext
    assign result_o.char_count = ucv_pkg::CharCountW'(total_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_q  <= 1'b0;
      pct_q   <= PctNone;
      seg_q   <= '0;
      phase_q <= PhaseStart;
      dots_q  <= 2'd0;
      digs_q  <= 2'd0;
      oval_q  <= 9'd0;
      total_q <= '0;
    end else begin
      fail_q  <= fail_d;
      pct_q   <= pct_d;
      seg_q   <= seg_d;
      phase_q <= phase_d;
      dots_q  <= dots_d;
      digs_q  <= digs_d;
      oval_q  <= oval_d;
      total_q <= total_d;
    end
  end

endmodule

[src/uri_component_validator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uri_component_validator
// Checks a byte string, one character per transfer, against the URI
// component grammar selected by the configuration register.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  cfg     | in        | cfg_valid/cfg_ready | cfg_component_kind_i
//  in      | in        | in_valid/in_stall   | in_action_i, in_char_byte_i
//  out     | out       | out_valid/out_stall | out_accepted_o, out_char_count_o
//
//  one item per cycle sustained unless an end item waits on a pending result;
//  an end item's result goes through the input register and the result register
//  a pending result holds an end item in the input register, which stalls
//  the input until the result is taken; character items never wait on it
//  reset clears the scan state, both registers' valid flags and selects
//  the segment grammar
// ----------------------------------------------------------------------------
module uri_component_validator #(
  parameter int unsigned COUNT_BITS = ucv_pkg::CountBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_component_kind_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_action_i,
  input  logic [7:0]  in_char_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_accepted_o,
  output logic [15:0] out_char_count_o
);

  ucv_pkg::ucv_kind_e   kind_q, kind_d;
  logic                 s1_valid_q, s1_valid_d;
  ucv_pkg::ucv_item_t   s1_item_q, s1_item_d;
  logic                 out_valid_q, out_valid_d;
  ucv_pkg::ucv_result_t out_q, out_d;
  ucv_pkg::ucv_result_t step_result;

  logic in_xfer;
  logic out_free;
  logic s1_fire;

  assign cfg_ready_o = 1'b1;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!s1_item_q.action || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    kind_d = kind_q;
    if (cfg_valid_i) kind_d = ucv_pkg::ucv_kind_e'(cfg_component_kind_i);
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_item_d  = s1_item_q;
    if (in_xfer) begin
      s1_valid_d          = 1'b1;
      s1_item_d.action    = in_action_i;
      s1_item_d.char_byte = in_char_byte_i;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (s1_fire && s1_item_q.action) begin
      out_valid_d = 1'b1;
      out_d       = step_result;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  ucv_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .kind_i   (kind_q),
    .fire_i   (s1_fire),
    .item_i   (s1_item_q),
    .result_o (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= ucv_pkg::KindReset;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      kind_q      <= kind_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q <= s1_item_d;
    out_q     <= out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign out_accepted_o   = out_q.accepted;
  assign out_char_count_o = out_q.char_count;

endmodule
